[rtl/ikd_pkg.sv]
// Shared constants, types and sequencer states for the index keystream decipher.
`default_nettype none

package ikd_pkg;

    // Generator geometry.
    localparam int MT_WORDS  = 624;
    localparam int MT_SHIFT  = 397;
    localparam int MT_SPLIT  = 227;
    localparam int MT_ADDR_W = $clog2(MT_WORDS);

    // Generator arithmetic constants.
    localparam logic [31:0] MT_INIT_MULT = 32'h6c07_8965;
    localparam logic [31:0] MT_MATRIX    = 32'h9908_b0df;
    localparam logic [31:0] MT_LOW_MASK  = 32'h7fff_ffff;
    localparam logic [31:0] MT_TEMPER_B  = 32'hff3a_58ad;
    localparam logic [31:0] MT_TEMPER_C  = 32'hffff_df8c;

    // Key schedule constants.
    localparam logic [7:0] KEY_FIRST_RESET  = 8'hc5;
    localparam logic [7:0] KEY_SECOND_RESET = 8'h89;
    localparam logic [7:0] KEY_STEP         = 8'h49;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED       = 2'd0,
        CFG_FIRST_KEY  = 2'd1,
        CFG_SECOND_KEY = 2'd2
    } cfg_index_t;

    // Generator sequencer states.
    typedef enum logic [2:0] {
        MT_IDLE,
        MT_SEED_MUL,
        MT_SEED_ADD,
        MT_GEN_RD0,
        MT_GEN_RD1,
        MT_GEN_RD2,
        MT_GEN_MIX
    } mt_state_t;

    // Request from the byte front end to the generator.
    typedef struct packed {
        logic        start;
        logic        reseed;
        logic        hold;
        logic [31:0] seed;
    } mt_req_t;

    // Answer from the generator.
    typedef struct packed {
        logic       done;
        logic [7:0] ks;
    } mt_rsp_t;

endpackage

`default_nettype wire

[rtl/index_keystream_decipher_top.sv]
// Top level of the index keystream decipher: stream ports, configuration and key schedule.
//
// Each input item is one enciphered index byte, with tuser[0] set on the first byte of an
// index. When a normal byte is accepted, three generator words are read out of the
// single-read-port state RAM. The current word is twisted in place and tempered, and the
// result item is registered when the generator leaves its mix state; the next byte can be
// accepted in the cycle after that, so one byte is in flight at a time. A byte that starts an
// index, or the first byte after reset, first runs the seeding pass. That pass writes all
// 624 generator words, the first with the seed and the rest through one registered
// multiplier. The result of such a byte is registered after the seeding pass and the
// operand reads, and the next byte can be accepted in the cycle after that.
// The seed and key start registers take effect at the next reseeding byte. A waiting result
// does not block acceptance of the next byte; the generator pauses only if it finishes
// while that result is still untaken.
`default_nettype none

module index_keystream_decipher_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] cipher_byte
    input  wire logic [0:0]                    s_tuser,   // [0] first_of_index
    // Output stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [7:0]                    m_tdata,   // [7:0] plain_byte
    // Configuration write port.
    input  wire logic                          cfg_wr_en,
    input  wire logic [ikd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    logic [31:0] seed_cfg_reg;
    logic [7:0]  first_start_reg;
    logic [7:0]  second_start_reg;

    logic        busy_reg, busy_next;
    logic        seeded_reg, seeded_next;
    logic [7:0]  cipher_reg, cipher_next;
    logic [7:0]  xor_key_reg, xor_key_next;
    logic [7:0]  key_inc_reg, key_inc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;

    logic        accept;
    logic        reseed;

    ikd_pkg::mt_req_t mt_req;
    ikd_pkg::mt_rsp_t mt_rsp;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign reseed   = s_tuser[0] || !seeded_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Generator request.
    always_comb
    begin
        mt_req.start  = accept;
        mt_req.reseed = reseed;
        mt_req.hold   = out_valid_reg && !m_tready;
        mt_req.seed   = seed_cfg_reg;
    end

    ikd_mt u_mt (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mt_req),
        .rsp  (mt_rsp)
    );

    // Configuration register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_cfg_reg     <= '0;
            first_start_reg  <= ikd_pkg::KEY_FIRST_RESET;
            second_start_reg <= ikd_pkg::KEY_SECOND_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ikd_pkg::CFG_SEED:       seed_cfg_reg     <= cfg_data;
                ikd_pkg::CFG_FIRST_KEY:  first_start_reg  <= cfg_data[7:0];
                ikd_pkg::CFG_SECOND_KEY: second_start_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Item tracking, key schedule and output register.
    always_comb
    begin
        busy_next      = busy_reg;
        seeded_next    = seeded_reg;
        cipher_next    = cipher_reg;
        xor_key_next   = xor_key_reg;
        key_inc_next   = key_inc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next   = 1'b1;
            cipher_next = s_tdata;
            if (reseed)
            begin
                seeded_next  = 1'b1;
                xor_key_next = first_start_reg;
                key_inc_next = second_start_reg;
            end
        end

        // The generator answers only while the output register can take the item.
        if (mt_rsp.done)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            out_data_next  = cipher_reg ^ mt_rsp.ks ^ xor_key_reg;
            xor_key_next   = xor_key_reg + key_inc_reg;
            key_inc_next   = key_inc_reg + ikd_pkg::KEY_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seeded_reg    <= 1'b0;
            xor_key_reg   <= ikd_pkg::KEY_FIRST_RESET;
            key_inc_reg   <= ikd_pkg::KEY_SECOND_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            seeded_reg    <= seeded_next;
            xor_key_reg   <= xor_key_next;
            key_inc_reg   <= key_inc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cipher_reg   <= cipher_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // A generator answer only arrives for an item in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        mt_rsp.done |-> busy_reg)
    else $error("keystream answer with no item in flight");

    // A finished item never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        mt_rsp.done |-> (!out_valid_reg || m_tready))
    else $error("result overwritten before it was taken");

    // Once an item has been accepted the block stays seeded.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> seeded_reg)
    else $error("item accepted without seeding");
`endif

endmodule

`default_nettype wire

[rtl/ikd_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ikd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/ikd_mt.sv]
// MT19937 keystream generator: seeding pass and incremental twist over one state RAM.
`default_nettype none

module ikd_mt (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ikd_pkg::mt_req_t req,
    output ikd_pkg::mt_rsp_t     rsp
);

    localparam int AW = ikd_pkg::MT_ADDR_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(ikd_pkg::MT_WORDS - 1);
    localparam logic [AW-1:0] SHIFT_OFS = AW'(ikd_pkg::MT_SHIFT);
    localparam logic [AW-1:0] SPLIT_OFS = AW'(ikd_pkg::MT_SPLIT);

    ikd_pkg::mt_state_t state_reg, state_next;

    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0]   prev_reg, prev_next;
    logic [31:0]   prod_reg;
    logic [31:0]   cur_reg;
    logic [31:0]   nxt_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [AW-1:0] pos_p1;
    logic [AW-1:0] pos_far;
    logic [31:0]   seed_word;
    logic [31:0]   mix_out;
    logic [31:0]   temper_out;

    // Combine the high bit of one word with the low bits of the next, then fold in the far word.
    function automatic logic [31:0] mix_word(input logic [31:0] hi, input logic [31:0] lo,
                                             input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] r;
        y = (hi & ~ikd_pkg::MT_LOW_MASK) | (lo & ikd_pkg::MT_LOW_MASK);
        r = far ^ (y >> 1);
        if (y[0])
        begin
            r = r ^ ikd_pkg::MT_MATRIX;
        end
        return r;
    endfunction

    // Output tempering.
    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y & ikd_pkg::MT_TEMPER_B) << 7);
        y = y ^ ((y & ikd_pkg::MT_TEMPER_C) << 15);
        y = y ^ (y >> 18);
        return y;
    endfunction

    ikd_ram #(
        .WIDTH(32),
        .DEPTH(ikd_pkg::MT_WORDS)
    ) u_state_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Neighbor and far addresses of the word being read, wrapping at the array end.
    assign pos_p1  = (pos_reg == LAST_WORD) ? '0 : pos_reg + AW'(1);
    assign pos_far = (pos_reg < SPLIT_OFS) ? pos_reg + SHIFT_OFS : pos_reg - SPLIT_OFS;

    // Seeding recurrence: the product is registered, and the index is added in the next cycle.
    assign seed_word = prod_reg + {{(32 - AW){1'b0}}, idx_reg};

    // Twist of the current word from the three words read, then tempering.
    assign mix_out    = mix_word(cur_reg, nxt_reg, ram_rdata);
    assign temper_out = temper(mix_out);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ikd_pkg::MT_IDLE:
            begin
                if (req.start)
                begin
                    state_next = req.reseed ? ikd_pkg::MT_SEED_MUL : ikd_pkg::MT_GEN_RD1;
                end
            end
            ikd_pkg::MT_SEED_MUL: state_next = ikd_pkg::MT_SEED_ADD;
            ikd_pkg::MT_SEED_ADD:
            begin
                state_next = (idx_reg == LAST_WORD) ? ikd_pkg::MT_GEN_RD0
                                                    : ikd_pkg::MT_SEED_MUL;
            end
            ikd_pkg::MT_GEN_RD0:  state_next = ikd_pkg::MT_GEN_RD1;
            ikd_pkg::MT_GEN_RD1:  state_next = ikd_pkg::MT_GEN_RD2;
            ikd_pkg::MT_GEN_RD2:  state_next = ikd_pkg::MT_GEN_MIX;
            ikd_pkg::MT_GEN_MIX:
            begin
                if (!req.hold)
                begin
                    state_next = ikd_pkg::MT_IDLE;
                end
            end
            default: state_next = ikd_pkg::MT_IDLE;
        endcase
    end

    // Sequencer outputs: RAM ports, counters and the answer.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = mix_out;
        ram_raddr = pos_reg;
        pos_next  = pos_reg;
        idx_next  = idx_reg;
        prev_next = prev_reg;
        rsp.done  = 1'b0;
        rsp.ks    = temper_out[7:0];
        unique case (state_reg)
            ikd_pkg::MT_IDLE:
            begin
                if (req.start && req.reseed)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = req.seed;
                    prev_next = req.seed;
                    idx_next  = AW'(1);
                    pos_next  = '0;
                end
            end
            ikd_pkg::MT_SEED_MUL:
            begin
            end
            ikd_pkg::MT_SEED_ADD:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = seed_word;
                prev_next = seed_word;
                idx_next  = idx_reg + AW'(1);
            end
            ikd_pkg::MT_GEN_RD0:
            begin
                ram_raddr = pos_reg;
            end
            ikd_pkg::MT_GEN_RD1:
            begin
                ram_raddr = pos_p1;
            end
            ikd_pkg::MT_GEN_RD2:
            begin
                ram_raddr = pos_far;
            end
            ikd_pkg::MT_GEN_MIX:
            begin
                ram_raddr = pos_far;
                if (!req.hold)
                begin
                    ram_we   = 1'b1;
                    rsp.done = 1'b1;
                    pos_next = pos_p1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ikd_pkg::MT_IDLE;
            pos_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        if (state_reg == ikd_pkg::MT_SEED_MUL)
        begin
            prod_reg <= ikd_pkg::MT_INIT_MULT * (prev_reg ^ (prev_reg >> 30));
        end
        if (state_reg == ikd_pkg::MT_GEN_RD1)
        begin
            cur_reg <= ram_rdata;
        end
        if (state_reg == ikd_pkg::MT_GEN_RD2)
        begin
            nxt_reg <= ram_rdata;
        end
    end

`ifndef NO_ASSERTIONS
    // The word position never leaves the state array.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_WORD)
    else $error("word position beyond the state array");

    // No state word is written while the three twist operands are being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ikd_pkg::MT_GEN_RD1 || state_reg == ikd_pkg::MT_GEN_RD2) |-> !ram_we)
    else $error("state RAM written during operand reads");

    // A keystream answer follows the full read sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(state_reg == ikd_pkg::MT_GEN_RD2 || state_reg == ikd_pkg::MT_GEN_MIX))
    else $error("keystream answer without operand reads");

    // The seeding pass hands over to reading at word zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ikd_pkg::MT_GEN_RD0) |-> (pos_reg == '0))
    else $error("seeding pass did not restart at word zero");
`endif

endmodule

`default_nettype wire
